[src/bms_pkg.sv]
// Shared types, command codes and note ROM for the buzzer melody sequencer.
// No dependencies; imported by every module of the block.
package bms_pkg;

    localparam int TIME_W   = 32;
    localparam int MEL_CNT  = 5;
    localparam int FREQ_W   = 11;
    localparam int DUR_W    = 8;
    localparam int CMD_W    = 2;
    localparam int SEL_W    = 3;
    localparam int POS_W    = 3;

    localparam logic [CMD_W-1:0] CMD_NONE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TONE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REST = 2'd2;
    localparam logic [CMD_W-1:0] CMD_STOP = 2'd3;

    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_PLAY = 1'b1;

    typedef struct packed {
        logic              action;
        logic [SEL_W-1:0]  sound;
        logic [TIME_W-1:0] now_ms;
    } t_in_item;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [FREQ_W-1:0] tone_freq_hz;
        logic [DUR_W-1:0]  tone_duration_ms;
        logic              busy_res;
    } t_out_item;

    // Number of notes in each melody; unused codes hold no notes.
    function automatic logic [POS_W-1:0] rom_len(input logic [SEL_W-1:0] sel);
        logic [POS_W-1:0] len;
        unique case (sel)
            3'd0:    len = 3'd2;
            3'd1:    len = 3'd3;
            3'd2:    len = 3'd2;
            3'd3:    len = 3'd3;
            3'd4:    len = 3'd4;
            default: len = 3'd0;
        endcase
        return len;
    endfunction

    // Note frequency in hertz, zero for a rest.
    function automatic logic [FREQ_W-1:0] rom_freq(input logic [SEL_W-1:0] sel,
                                                   input logic [POS_W-1:0] pos);
        logic [FREQ_W-1:0] f;
        unique case ({sel, pos})
            {3'd0, 3'd0}: f = 11'd1047;
            {3'd0, 3'd1}: f = 11'd1319;
            {3'd1, 3'd0}: f = 11'd1319;
            {3'd1, 3'd1}: f = 11'd1568;
            {3'd1, 3'd2}: f = 11'd1047;
            {3'd2, 3'd0}: f = 11'd784;
            {3'd2, 3'd1}: f = 11'd659;
            {3'd3, 3'd0}: f = 11'd523;
            {3'd3, 3'd2}: f = 11'd523;
            {3'd4, 3'd0}: f = 11'd523;
            {3'd4, 3'd1}: f = 11'd659;
            {3'd4, 3'd2}: f = 11'd784;
            {3'd4, 3'd3}: f = 11'd1047;
            default:      f = 11'd0;
        endcase
        return f;
    endfunction

    // Note duration in milliseconds.
    function automatic logic [DUR_W-1:0] rom_dur(input logic [SEL_W-1:0] sel,
                                                 input logic [POS_W-1:0] pos);
        logic [DUR_W-1:0] d;
        unique case ({sel, pos})
            {3'd0, 3'd0}: d = 8'd60;
            {3'd0, 3'd1}: d = 8'd90;
            {3'd1, 3'd0}: d = 8'd50;
            {3'd1, 3'd1}: d = 8'd50;
            {3'd1, 3'd2}: d = 8'd90;
            {3'd2, 3'd0}: d = 8'd90;
            {3'd2, 3'd1}: d = 8'd130;
            {3'd3, 3'd0}: d = 8'd200;
            {3'd3, 3'd1}: d = 8'd100;
            {3'd3, 3'd2}: d = 8'd200;
            {3'd4, 3'd0}: d = 8'd80;
            {3'd4, 3'd1}: d = 8'd80;
            {3'd4, 3'd2}: d = 8'd80;
            {3'd4, 3'd3}: d = 8'd140;
            default:      d = 8'd0;
        endcase
        return d;
    endfunction

endpackage

[src/bms_player.sv]
// Playback state and per-item step logic of the buzzer melody sequencer.
// Depends on bms_pkg for item types, command codes and the note ROM.
module bms_player
    import bms_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_fire,
    input  t_in_item  i_item,
    output t_out_item o_result
);

    logic              r_playing, n_playing;
    logic [SEL_W-1:0]  r_sel, n_sel;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [TIME_W-1:0] r_end, n_end;

    logic [FREQ_W-1:0] note_freq;
    logic [DUR_W-1:0]  note_dur;
    logic              at_end;

    // Look up the current note
    assign note_freq = rom_freq(r_sel, r_pos);
    assign note_dur  = rom_dur(r_sel, r_pos);
    assign at_end    = (r_pos >= rom_len(r_sel));

    // Work out the result and the next state for one item
    always_comb begin
        n_playing = r_playing;
        n_sel     = r_sel;
        n_pos     = r_pos;
        n_end     = r_end;
        o_result  = '{command: CMD_NONE, tone_freq_hz: '0, tone_duration_ms: '0,
                      busy_res: r_playing};
        if (i_item.action == ACT_PLAY) begin
            if (i_item.sound < SEL_W'(MEL_CNT)) begin
                n_playing = 1'b1;
                n_sel     = i_item.sound;
                n_pos     = '0;
                n_end     = '0;
                o_result.busy_res = 1'b1;
            end
        end else if (r_playing && (i_item.now_ms >= r_end)) begin
            if (at_end) begin
                n_playing = 1'b0;
                o_result.command  = CMD_STOP;
                o_result.busy_res = 1'b0;
            end else begin
                n_pos = r_pos + POS_W'(1);
                n_end = i_item.now_ms + TIME_W'(note_dur);
                o_result.tone_duration_ms = note_dur;
                if (note_freq != '0) begin
                    o_result.command      = CMD_TONE;
                    o_result.tone_freq_hz = note_freq;
                end else begin
                    o_result.command = CMD_REST;
                end
            end
        end
    end

    // Commit the state when the item moves on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_playing <= 1'b0;
            r_sel     <= '0;
            r_pos     <= '0;
            r_end     <= '0;
        end else if (i_fire) begin
            r_playing <= n_playing;
            r_sel     <= n_sel;
            r_pos     <= n_pos;
            r_end     <= n_end;
        end
    end

endmodule

[src/buzzer_melody_sequencer.sv]
// Buzzer melody sequencer top level: input register, step logic, result register.
// Each item moves from the input register via the step logic to the result register.
// Throughput: one item per cycle unless stalled; step logic: ROM reads, compares, adds.
// A stalled result register holds and the input register fills behind it.
// Synchronous active-low reset empties both registers and sets the player idle.
// Depends on bms_pkg and bms_player.
module buzzer_melody_sequencer
    import bms_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;
    t_out_item step_res;
    logic      out_free;
    logic      fire;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;

    // Step the player on the registered item
    bms_player u_player (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_in),
        .o_result (step_res)
    );

    // Input register: load whenever not stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_in <= i_in_item;
        end
    end

    // Result register: advance when free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= step_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

[src/bms_checker.sv]
// Port-level checks for buzzer_melody_sequencer, attached by bind.
// Depends on bms_pkg for item types and command codes.
module bms_checker
    import bms_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_out_valid,
    input logic      i_out_stall,
    input t_out_item i_out_item
);

    // Stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid && $stable(i_out_item))
        else $error("stalled result changed");

    // Stop always leaves the player idle
    a_stop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_item.command == CMD_STOP |-> !i_out_item.busy_res)
        else $error("stop with busy set");

    // A started tone or rest keeps the melody active and carries a duration
    a_note: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_item.command == CMD_TONE || i_out_item.command == CMD_REST)
        |-> i_out_item.busy_res && i_out_item.tone_duration_ms != '0)
        else $error("note without duration or busy");

    // Frequency present exactly on tones
    a_freq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((i_out_item.command == CMD_TONE) == (i_out_item.tone_freq_hz != '0)))
        else $error("frequency does not match command");

    // No change means no note data
    a_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_item.command == CMD_NONE |-> i_out_item.tone_duration_ms == '0)
        else $error("duration on no-change result");

endmodule

bind buzzer_melody_sequencer bms_checker u_bms_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_item  (o_out_item)
);
